// ===== hdl/swpd_pkg.sv =====
// Shared types and constants of the sliding window peak detector.
// Used by the front, back and top-level modules; depends on nothing else.
package swpd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                eov;
    } t_item;

    typedef struct packed {
        logic is_peak;
        logic last;
    } t_result;

endpackage

// ===== hdl/sliding_window_peak_detector.sv =====
// Sliding window strict local maximum detector, top level.
// Takes one sample per cycle through an input queue while it is not full; the
// window engine shifts one entry per cycle unless the result queue is full or no
// item or flush step is waiting, and judges the centre against RADIUS neighbors on
// each side with parallel comparators. After a sample marked end_of_vector the
// engine flushes the remaining RADIUS positions one per cycle, under the same stall,
// before it takes the next sample. Results leave through a queue, where each result
// is registered before it is on the ports.
// Depends on swpd_pkg, swpd_front, swpd_back and swpd_fifo.
module sliding_window_peak_detector #(
    parameter int RADIUS      = 10,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [swpd_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic                          i_end_of_vector,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_is_peak,
    output logic                          o_last_result
);

    swpd_pkg::t_item   item;
    swpd_pkg::t_result result;
    logic              item_empty;
    logic              item_pop;

    swpd_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_sample_value (i_sample_value),
        .i_end_of_vector(i_end_of_vector),
        .o_full         (full),
        .i_pop          (item_pop),
        .o_item         (item),
        .o_empty        (item_empty)
    );

    swpd_back #(
        .RADIUS     (RADIUS),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .i_item_empty(item_empty),
        .o_item_pop  (item_pop),
        .i_pop       (pop),
        .o_result    (result),
        .o_empty     (empty)
    );

    assign o_is_peak     = result.is_peak;
    assign o_last_result = result.last;

endmodule

// ===== hdl/swpd_fifo.sv =====
// Small register-based first-in first-out queue with full and empty flags.
// Generic in width and depth; used for the input and result queues of the peak detector.
module swpd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hdl/swpd_front.sv =====
// Front end of the peak detector: accepts samples, masks them to the value width
// and queues them with their end-of-vector tag. Depends on swpd_pkg and swpd_fifo.
module swpd_front #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic [swpd_pkg::SAMPLE_W-1:0]    i_sample_value,
    input  logic                             i_end_of_vector,
    output logic                             o_full,
    input  logic                             i_pop,
    output swpd_pkg::t_item                  o_item,
    output logic                             o_empty
);

    localparam int VW = (VALUE_WIDTH < swpd_pkg::SAMPLE_W) ? VALUE_WIDTH : swpd_pkg::SAMPLE_W;
    localparam logic [swpd_pkg::SAMPLE_W-1:0] MASK = swpd_pkg::SAMPLE_W'((2 ** VW) - 1);

    swpd_pkg::t_item item_in;
    logic [$bits(swpd_pkg::t_item)-1:0] item_out;

    always_comb begin
        item_in.value = i_sample_value & MASK;
        item_in.eov   = i_end_of_vector;
    end

    swpd_fifo #(
        .WIDTH($bits(swpd_pkg::t_item)),
        .DEPTH(swpd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push),
        .i_data (item_in),
        .o_full (o_full),
        .i_pop  (i_pop),
        .o_data (item_out),
        .o_empty(o_empty)
    );

    assign o_item = item_out;

endmodule

// ===== hdl/swpd_back.sv =====
// Back end of the peak detector: the sample window with valid marks, the flush
// sequencer and the result queue. Depends on swpd_pkg and swpd_fifo.
module swpd_back #(
    parameter int RADIUS      = 10,
    parameter int VALUE_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swpd_pkg::t_item   i_item,
    input  logic              i_item_empty,
    output logic              o_item_pop,
    input  logic              i_pop,
    output swpd_pkg::t_result o_result,
    output logic              o_empty
);

    localparam int VW  = (VALUE_WIDTH < swpd_pkg::SAMPLE_W) ? VALUE_WIDTH : swpd_pkg::SAMPLE_W;
    localparam int WIN = 2 * RADIUS + 1;
    localparam int FW  = $clog2(RADIUS + 1);

    logic [VW-1:0]  r_win [WIN];
    logic [VW-1:0]  n_win [WIN];
    logic [WIN-1:0] r_vld, n_vld, shift_vld;
    logic           r_flush, n_flush;
    logic [FW-1:0]  r_flush_cnt, n_flush_cnt;
    logic           res_full;
    logic           step;
    logic           final_step;
    logic           peak;
    swpd_pkg::t_result res_in;
    logic [$bits(swpd_pkg::t_result)-1:0] res_out;

    assign step       = !res_full && (r_flush || !i_item_empty);
    assign o_item_pop = step && !r_flush;
    assign final_step = r_flush && (r_flush_cnt == FW'(1));

    always_comb begin
        n_win[0]     = r_flush ? '0 : i_item.value[VW-1:0];
        shift_vld[0] = !r_flush;
        for (int k = 1; k < WIN; k++) begin
            n_win[k]     = r_win[k-1];
            shift_vld[k] = r_vld[k-1];
        end
    end

    always_comb begin
        peak = 1'b1;
        for (int d = 1; d <= RADIUS; d++) begin
            if (shift_vld[RADIUS-d] && (n_win[RADIUS] <= n_win[RADIUS-d])) begin
                peak = 1'b0;
            end
            if (shift_vld[RADIUS+d] && (n_win[RADIUS] <= n_win[RADIUS+d])) begin
                peak = 1'b0;
            end
        end
    end

    always_comb begin
        res_in.is_peak = peak;
        res_in.last    = final_step;
    end

    always_comb begin
        n_vld       = r_vld;
        n_flush     = r_flush;
        n_flush_cnt = r_flush_cnt;
        if (step) begin
            n_vld = final_step ? '0 : shift_vld;
            if (r_flush) begin
                n_flush_cnt = r_flush_cnt - FW'(1);
                n_flush     = !final_step;
            end else if (i_item.eov) begin
                n_flush     = 1'b1;
                n_flush_cnt = FW'(RADIUS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_flush     <= 1'b0;
            r_flush_cnt <= '0;
        end else begin
            r_vld       <= n_vld;
            r_flush     <= n_flush;
            r_flush_cnt <= n_flush_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_win <= n_win;
        end
    end

    swpd_fifo #(
        .WIDTH($bits(swpd_pkg::t_result)),
        .DEPTH(swpd_pkg::QUEUE_DEPTH)
    ) u_results (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (step && shift_vld[RADIUS]),
        .i_data (res_in),
        .o_full (res_full),
        .i_pop  (i_pop),
        .o_data (res_out),
        .o_empty(o_empty)
    );

    assign o_result = res_out;

endmodule

// ===== hdl/swpd_checker.sv =====
// Port-level checks of the sliding window peak detector, bound to the top level.
// Depends only on the ports of sliding_window_peak_detector.
module swpd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic full,
    input logic empty,
    input logic pop,
    input logic o_is_peak,
    input logic o_last_result
);

    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("Result queue is not empty after reset.");

    a_ready_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("Input queue is full after reset.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("A waiting result vanished without a pop.");

    a_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> $stable({o_is_peak, o_last_result}))
        else $error("A waiting result changed without a pop.");

endmodule

bind sliding_window_peak_detector swpd_checker u_swpd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_is_peak    (o_is_peak),
    .o_last_result(o_last_result)
);

// ===== tb/tb_sliding_window_peak_detector.sv =====
// Testbench for the sliding window peak detector: directed and random vectors.
// A local window model predicts each peak flag, and a checker compares every popped result.
// Depends on swpd_pkg and sliding_window_peak_detector.
module tb_sliding_window_peak_detector;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RADIUS      = 10;
    localparam int VALUE_WIDTH = 16;
    localparam int WIN_LEN     = 2 * RADIUS + 1;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          push            = 1'b0;
    logic                          full;
    logic [swpd_pkg::SAMPLE_W-1:0] i_sample_value  = '0;
    logic                          i_end_of_vector = 1'b0;
    logic                          empty;
    logic                          pop             = 1'b0;
    logic                          o_is_peak;
    logic                          o_last_result;

    logic [VALUE_WIDTH-1:0] win_vals [WIN_LEN];
    logic                   win_ok   [WIN_LEN];
    swpd_pkg::t_result      peak_flags_due [$];
    swpd_pkg::t_result      due_flag;

    int send_idle_pct  = 0;
    int pop_stall_pct  = 0;
    int error_count    = 0;
    int samples_sent   = 0;
    int vectors_sent   = 0;
    int flags_checked  = 0;
    int peaks_seen     = 0;

    sliding_window_peak_detector #(
        .RADIUS      (RADIUS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_sample_value  (i_sample_value),
        .i_end_of_vector (i_end_of_vector),
        .empty           (empty),
        .pop             (pop),
        .o_is_peak       (o_is_peak),
        .o_last_result   (o_last_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic centre_wins();
        logic [VALUE_WIDTH-1:0] c;
        c = win_vals[RADIUS];
        for (int d = 1; d <= RADIUS; d++) begin
            if (win_ok[RADIUS - d] && c <= win_vals[RADIUS - d]) return 1'b0;
            if (win_ok[RADIUS + d] && c <= win_vals[RADIUS + d]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic shift_window(input logic [VALUE_WIDTH-1:0] v, input logic ok);
        for (int k = WIN_LEN - 1; k > 0; k--) begin
            win_vals[k] = win_vals[k - 1];
            win_ok[k]   = win_ok[k - 1];
        end
        win_vals[0] = v;
        win_ok[0]   = ok;
    endtask

    task automatic judge_centre(input logic last);
        swpd_pkg::t_result r;
        if (win_ok[RADIUS]) begin
            r.is_peak = centre_wins();
            r.last    = last;
            peak_flags_due.push_back(r);
        end
    endtask

    task automatic predict_peaks(input logic [swpd_pkg::SAMPLE_W-1:0] v, input logic eov);
        shift_window(v[VALUE_WIDTH-1:0], 1'b1);
        judge_centre(eov && RADIUS == 0);
        if (eov) begin
            for (int k = 1; k <= RADIUS; k++) begin
                shift_window('0, 1'b0);
                judge_centre(k == RADIUS);
            end
            for (int k = 0; k < WIN_LEN; k++) win_ok[k] = 1'b0;
            vectors_sent++;
        end
    endtask

    task automatic send_sample(input logic [swpd_pkg::SAMPLE_W-1:0] v, input logic eov);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push            = 1'b1;
        i_sample_value  = v;
        i_end_of_vector = eov;
        do @(posedge i_clk); while (full);
        predict_peaks(v, eov);
        samples_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        push = 1'b0;
        while (peak_flags_due.size() != 0) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        pop = ($urandom_range(99) >= pop_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            flags_checked++;
            if (peak_flags_due.size() == 0) begin
                $error("Unexpected result transaction: is_peak %0b, last_result %0b",
                       o_is_peak, o_last_result);
                error_count++;
            end else begin
                due_flag = peak_flags_due.pop_front();
                if (o_is_peak !== due_flag.is_peak) begin
                    $error("is_peak mismatch: expected %0b, actual %0b",
                           due_flag.is_peak, o_is_peak);
                    error_count++;
                end
                if (o_last_result !== due_flag.last) begin
                    $error("last_result mismatch: expected %0b, actual %0b",
                           due_flag.last, o_last_result);
                    error_count++;
                end
                if (due_flag.is_peak) peaks_seen++;
            end
        end
    end

    task automatic test_single_element_vectors();
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b1);
    endtask

    task automatic test_extreme_values();
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFE, 1'b1);
    endtask

    task automatic test_equal_neighbors();
        send_sample(16'h0005, 1'b0);
        send_sample(16'h0005, 1'b0);
        send_sample(16'h0005, 1'b1);
    endtask

    task automatic test_radius_boundary();
        send_sample(16'hFFFF, 1'b0);
        for (int i = 1; i < RADIUS + 1; i++) send_sample(16'(i * 16'h1111), 1'b0);
        send_sample(16'hFFFF, 1'b1);
    endtask

    task automatic send_random_vector();
        int len;
        int style;
        logic [swpd_pkg::SAMPLE_W-1:0] v;
        len   = ($urandom_range(4) == 0) ? $urandom_range(RADIUS + 1, 3 * RADIUS)
                                         : $urandom_range(1, RADIUS + 4);
        style = $urandom_range(3);
        v     = swpd_pkg::SAMPLE_W'($urandom);
        for (int i = 0; i < len; i++) begin
            case (style)
                0: begin
                    v = swpd_pkg::SAMPLE_W'($urandom);
                end
                1: begin
                    v = swpd_pkg::SAMPLE_W'($urandom_range(3));
                end
                2: begin
                    v = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
                end
                default: begin
                    v = v + 16'($urandom_range(6)) - 16'd3;
                end
            endcase
            send_sample(v, i == len - 1);
        end
    endtask

    task automatic test_random_vectors(input int idle_pct, input int stall_pct,
                                       input int n_samples);
        int stop_at;
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        stop_at       = samples_sent + n_samples;
        while (samples_sent < stop_at) send_random_vector();
    endtask

    task automatic test_drain_pause();
        send_random_vector();
        wait_for_drain();
        send_random_vector();
    endtask

    initial begin
        for (int k = 0; k < WIN_LEN; k++) begin
            win_vals[k] = '0;
            win_ok[k]   = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_single_element_vectors();
        test_extreme_values();
        test_equal_neighbors();
        test_radius_boundary();

        test_random_vectors(0, 0, 15);
        test_random_vectors(73, 0, 15);
        test_random_vectors(0, 73, 15);
        test_drain_pause();
        test_random_vectors(17, 17, 15);

        @(negedge i_clk);
        push = 1'b0;
        wait_for_drain();
        repeat (RADIUS + 10) @(posedge i_clk);

        $display("Sent %0d samples in %0d vectors under four idle and stall mixes.",
                 samples_sent, vectors_sent);
        $display("Checked %0d result transactions, %0d of them peaks.",
                 flags_checked, peaks_seen);
        if (error_count == 0 && peak_flags_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
